// ===== rtl/dhc_pkg.sv =====
// Package for the dual hysteresis on/off controller.
// Types, codes and constants shared by all rtl files; no dependencies.
`timescale 1ns / 1ps
package dhc_pkg;

    localparam logic [15:0] MIN_REPEAT_S = 16'd60;
    localparam int MAX_RESULTS = 4;

    typedef enum logic [1:0] {
        ST_OFF  = 2'd0,
        ST_ON   = 2'd1,
        ST_IDLE = 2'd2
    } chan_state_t;

    typedef enum logic [1:0] {
        FUNC_EVAL = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_STOP = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_FLAGS   = 3'd0,
        REG_ACTIONS = 3'd1,
        REG_PERIOD  = 3'd2,
        REG_TLOW    = 3'd3,
        REG_THIGH   = 3'd4,
        REG_HLOW    = 3'd5,
        REG_HHIGH   = 3'd6,
        REG_SPARE   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [3:0]         flags;
        logic [1:0]         actions;
        logic [15:0]        period;
        logic signed [15:0] temp_low;
        logic signed [15:0] temp_high;
        logic [13:0]        hum_low;
        logic [13:0]        hum_high;
    } cfg_t;

    typedef struct packed {
        logic [1:0] func;
        logic signed [15:0] temp_value;
        logic [13:0] hum_value;
        logic active;
    } in_item_t;

    typedef struct packed {
        logic channel;
        logic command;
    } cmd_t;

    // up to four commands from one item
    typedef struct packed {
        logic [2:0] count;
        cmd_t [3:0] cmds;
    } burst_t;

endpackage

// ===== rtl/dhc_if.sv =====
// Valid/ready channel interfaces for input items and command items.
// Depends on dhc_pkg.
`timescale 1ns / 1ps
interface dhc_in_if import dhc_pkg::*; ;
    logic valid;
    logic ready;
    logic [1:0] func;
    logic signed [15:0] temp_value;
    logic [13:0] hum_value;
    logic active;
    modport source (output valid, func, temp_value, hum_value, active, input ready);
    modport sink (input valid, func, temp_value, hum_value, active, output ready);
endinterface

interface dhc_out_if;
    logic valid;
    logic ready;
    logic channel;
    logic command;
    logic last;
    modport source (output valid, channel, command, last, input ready);
    modport sink (input valid, channel, command, last, output ready);
endinterface

// ===== rtl/dhc_cfg.sv =====
// Configuration register file for the controller.
// Depends on dhc_pkg.
`timescale 1ns / 1ps
module dhc_cfg
    import dhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flags     <= 4'd0;
            cfg_reg.actions   <= 2'd0;
            cfg_reg.period    <= 16'd60;
            cfg_reg.temp_low  <= 16'sd2000;
            cfg_reg.temp_high <= 16'sd2500;
            cfg_reg.hum_low   <= 14'd4000;
            cfg_reg.hum_high  <= 14'd6000;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_FLAGS:   cfg_reg.flags     <= cfg_data[3:0];
                REG_ACTIONS: cfg_reg.actions   <= cfg_data[1:0];
                REG_PERIOD:  cfg_reg.period    <= cfg_data;
                REG_TLOW:    cfg_reg.temp_low  <= cfg_data;
                REG_THIGH:   cfg_reg.temp_high <= cfg_data;
                REG_HLOW:    cfg_reg.hum_low   <= cfg_data[13:0];
                REG_HHIGH:   cfg_reg.hum_high  <= cfg_data[13:0];
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== rtl/dhc_core.sv =====
// Control state and the single-pass evaluate/tick/stop logic.
// Depends on dhc_pkg.
`timescale 1ns / 1ps
module dhc_core
    import dhc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     item_valid,
    input  in_item_t item,
    output burst_t   burst
);
    chan_state_t [1:0] st_reg, st_next;
    chan_state_t [1:0] cb_reg, cb_next;
    logic [15:0] sv_t_reg, sv_t_next;
    logic [13:0] sv_h_reg, sv_h_next;
    logic [1:0][15:0] cd_reg, cd_next;
    logic [1:0] arm_reg, arm_next;

    // value/10 truncated toward zero, via reciprocal multiply on magnitude
    function automatic logic signed [16:0] div10(input logic signed [16:0] v);
        logic [16:0] m;
        logic [34:0] p;
        logic [16:0] q;
        m = v[16] ? 17'(-v) : 17'(v);
        p = 35'(m) * 35'd52429;
        q = 17'(p >> 19);
        div10 = v[16] ? -$signed(q) : $signed(q);
    endfunction

    always_comb
    begin
        logic [15:0] ivl;
        logic one, rep, te, he, offon, hit, on, up, dn;
        logic signed [16:0] v, lo, hi, sv;
        logic [2:0] n;
        int oc, fc;

        st_next = st_reg; cb_next = cb_reg;
        sv_t_next = sv_t_reg; sv_h_next = sv_h_reg;
        cd_next = cd_reg; arm_next = arm_reg;
        burst = '0;
        n = 3'd0;
        ivl = (cfg.period <= MIN_REPEAT_S) ? MIN_REPEAT_S : cfg.period;
        one = cfg.flags[3]; rep = cfg.flags[2];
        te = cfg.flags[0]; he = cfg.flags[1];
        v = '0; lo = '0; hi = '0; sv = '0;
        offon = 1'b0; hit = 1'b0; on = 1'b0; up = 1'b0; dn = 1'b0;
        oc = 0; fc = 0;

        if (item_valid)
        begin
            case (func_t'(item.func))
                FUNC_EVAL:
                begin
                    if (item.active)
                    begin
                        for (int ch = 0; ch < 2; ch++)
                        begin
                            if (ch == 0)
                            begin
                                v = 17'(item.temp_value);
                                lo = 17'(cfg.temp_low); hi = 17'(cfg.temp_high);
                            end
                            else
                            begin
                                v = $signed({3'b0, item.hum_value});
                                lo = $signed({3'b0, cfg.hum_low});
                                hi = $signed({3'b0, cfg.hum_high});
                            end
                            offon = cfg.actions[ch];
                            hit = 1'b0;
                            if (!cfg.flags[ch])
                            begin
                                arm_next[ch] = 1'b0; cd_next[ch] = '0;
                                if (!one)
                                begin
                                    if (st_next[ch] == ST_ON)
                                    begin
                                        burst.cmds[n[1:0]] = '{1'(ch), 1'b0}; n = n + 3'd1;
                                    end
                                    st_next[ch] = ST_IDLE;
                                end
                            end
                            else
                            begin
                                if (!rep && arm_next[ch])
                                begin
                                    arm_next[ch] = 1'b0; cd_next[ch] = '0;
                                end
                                if (st_next[ch] == ST_IDLE)
                                begin
                                    on = offon ? (v > lo) : (v < hi);
                                    st_next[ch] = on ? ST_ON : ST_OFF;
                                    hit = 1'b1;
                                end
                                else if (st_next[ch] == ST_OFF)
                                begin
                                    if ((v >= hi && offon) || (v <= lo && !offon))
                                    begin
                                        st_next[ch] = ST_ON; on = 1'b1; hit = 1'b1;
                                    end
                                end
                                else if ((v >= hi && !offon) || (v <= lo && offon))
                                begin
                                    st_next[ch] = ST_OFF; on = 1'b0; hit = 1'b1;
                                end
                                if (hit)
                                begin
                                    if (ch == 0) sv_t_next = v[15:0];
                                    else sv_h_next = v[13:0];
                                    if (!one)
                                    begin
                                        arm_next[ch] = rep;
                                        cd_next[ch] = rep ? ivl : 16'd0;
                                        burst.cmds[n[1:0]] = '{1'(ch), on}; n = n + 3'd1;
                                    end
                                end
                            end
                        end
                        if (one)
                        begin
                            if (!te && !he)
                            begin
                                arm_next = '0; cd_next = '0;
                                if (st_next[0] == ST_ON || st_next[1] == ST_ON)
                                begin
                                    burst.cmds[n[1:0]] = '{1'b0, 1'b0}; n = n + 3'd1;
                                end
                                st_next = {ST_IDLE, ST_IDLE};
                                cb_next = {ST_IDLE, ST_IDLE};
                            end
                            else if (te != he)
                            begin
                                oc = te ? 0 : 1; fc = 1 - oc;
                                arm_next[fc] = 1'b0; cd_next[fc] = '0;
                                if (st_next[fc] == ST_ON && st_next[oc] == ST_OFF)
                                begin
                                    burst.cmds[n[1:0]] = '{1'(fc), 1'b0}; n = n + 3'd1;
                                end
                                st_next[fc] = ST_IDLE; cb_next[fc] = ST_IDLE;
                                if (st_next[oc] == ST_ON && cb_next[oc] != ST_ON)
                                begin
                                    cb_next[oc] = ST_ON;
                                    burst.cmds[n[1:0]] = '{1'(oc), 1'b1}; n = n + 3'd1;
                                    arm_next[oc] = 1'b0; cd_next[oc] = '0;
                                end
                                if (st_next[oc] == ST_OFF && cb_next[oc] != ST_OFF)
                                begin
                                    cb_next[oc] = ST_OFF;
                                    burst.cmds[n[1:0]] = '{1'(oc), 1'b0}; n = n + 3'd1;
                                    arm_next[oc] = 1'b0; cd_next[oc] = '0;
                                end
                                if (!arm_next[oc] && rep)
                                begin
                                    arm_next[oc] = 1'b1; cd_next[oc] = ivl;
                                end
                            end
                            else
                            begin
                                for (int ch = 0; ch < 2; ch++)
                                begin
                                    if (st_next[ch] == ST_ON && cb_next[ch] != ST_ON)
                                    begin
                                        cb_next[ch] = ST_ON;
                                        burst.cmds[n[1:0]] = '{1'(ch), 1'b1}; n = n + 3'd1;
                                        arm_next = '0; cd_next = '0;
                                        if (rep)
                                        begin
                                            arm_next[ch] = 1'b1; cd_next[ch] = ivl;
                                        end
                                    end
                                end
                                for (int ch = 0; ch < 2; ch++)
                                begin
                                    if (st_next[ch] == ST_OFF && cb_next[ch] != ST_OFF)
                                    begin
                                        cb_next[ch] = ST_OFF;
                                        if (cb_next[1 - ch] == ST_OFF)
                                        begin
                                            burst.cmds[n[1:0]] = '{1'(ch), 1'b0};
                                            n = n + 3'd1;
                                            arm_next = '0; cd_next = '0;
                                            if (rep)
                                            begin
                                                arm_next[ch] = 1'b1; cd_next[ch] = ivl;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                FUNC_TICK:
                begin
                    for (int ch = 0; ch < 2; ch++)
                    begin
                        if (arm_reg[ch])
                        begin
                            if (cd_reg[ch] > 16'd1)
                                cd_next[ch] = cd_reg[ch] - 16'd1;
                            else if (!rep)
                            begin
                                arm_next[ch] = 1'b0; cd_next[ch] = '0;
                            end
                            else
                            begin
                                cd_next[ch] = ivl;
                                offon = cfg.actions[ch];
                                on = (st_reg[ch] != ST_OFF);
                                if (ch == 0)
                                begin
                                    v = 17'(item.temp_value);
                                    sv = 17'($signed(sv_t_reg));
                                end
                                else
                                begin
                                    v = $signed({3'b0, item.hum_value});
                                    sv = $signed({3'b0, sv_h_reg});
                                end
                                up = div10(v) >= div10(sv);
                                dn = div10(v) <= div10(sv);
                                if (one && cfg.flags[1 - ch])
                                begin
                                    burst.cmds[n[1:0]] = '{1'(ch), on}; n = n + 3'd1;
                                end
                                else if (on)
                                begin
                                    if ((up && offon) || (dn && !offon))
                                    begin
                                        burst.cmds[n[1:0]] = '{1'(ch), 1'b1}; n = n + 3'd1;
                                    end
                                end
                                else if ((up && !offon) || (dn && offon))
                                begin
                                    burst.cmds[n[1:0]] = '{1'(ch), 1'b0}; n = n + 3'd1;
                                end
                            end
                        end
                    end
                end
                FUNC_STOP:
                begin
                    arm_next = '0; cd_next = '0;
                    st_next = {ST_IDLE, ST_IDLE};
                    cb_next = {ST_IDLE, ST_IDLE};
                end
                default: ;
            endcase
        end
        burst.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= {ST_IDLE, ST_IDLE};
            cb_reg <= {ST_IDLE, ST_IDLE};
            sv_t_reg <= '0;
            sv_h_reg <= '0;
            cd_reg <= '0;
            arm_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            cb_reg <= cb_next;
            sv_t_reg <= sv_t_next;
            sv_h_reg <= sv_h_next;
            cd_reg <= cd_next;
            arm_reg <= arm_next;
        end
    end
endmodule

// ===== rtl/dhc_drain.sv =====
// Holds the commands of one item and sends them one per cycle while the receiver is ready.
// Depends on dhc_pkg.
`timescale 1ns / 1ps
module dhc_drain
    import dhc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  burst_t burst,
    output logic   empty,
    output logic   out_valid,
    input  logic   out_ready,
    output logic   out_channel,
    output logic   out_command,
    output logic   out_last
);
    cmd_t [3:0] cmds_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] pos_reg, pos_next;

    assign out_valid = (cnt_reg != 3'd0);
    assign empty = !out_valid || (out_ready && cnt_reg == 3'd1);
    assign out_channel = cmds_reg[pos_reg].channel;
    assign out_command = cmds_reg[pos_reg].command;
    assign out_last = (cnt_reg == 3'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (out_valid && out_ready)
        begin
            cnt_next = cnt_reg - 3'd1;
            pos_next = pos_reg + 2'd1;
        end
        if (load)
        begin
            cnt_next = burst.count;
            pos_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmds_reg <= burst.cmds;
    end
endmodule

// ===== rtl/dual_hysteresis_onoff_controller.sv =====
// Top level of the dual hysteresis on/off controller.
// Depends on dhc_pkg, dhc_if, dhc_cfg, dhc_core and dhc_drain.
// Usage:
//  - in_ch carries items (func, temp_value, hum_value, active); an item is
//    taken when valid and ready are high at a clock edge.
//  - out_ch carries the commands caused by an item, zero to four of them,
//    one per cycle while the receiver is ready; last marks the final command of the item.
//  - cfg_we/cfg_index/cfg_data write a register; write only while idle.
//  - An accepted item is registered, evaluated in one pass once the drain
//    can take its commands, and its commands are sent from the drain register.
//  - Throughput: one item per cycle for items without commands while the
//    drain is empty; an item with commands makes the next item wait in the
//    input register until its last command is sent, so the command drain register sets the rate.
//  - If the receiver stalls, the drain holds its commands; the input
//    register still takes one more item, then ready drops.
//  - Reset puts both channels in IDLE, disarms the repeat timers and loads
//    the register defaults.
`timescale 1ns / 1ps
module dual_hysteresis_onoff_controller
    import dhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dhc_in_if.sink      in_ch,
    dhc_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    cfg_t cfg;
    in_item_t item_reg;
    logic item_vld_reg;
    logic drain_empty;
    logic take_item;
    burst_t burst;

    dhc_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    // stage item is consumed only when the drain can take its commands
    assign take_item = item_vld_reg && drain_empty;
    assign in_ch.ready = !item_vld_reg || drain_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (in_ch.ready)
            item_vld_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg.func <= in_ch.func;
            item_reg.temp_value <= in_ch.temp_value;
            item_reg.hum_value <= in_ch.hum_value;
            item_reg.active <= in_ch.active;
        end
    end

    dhc_core u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .item_valid(take_item),
        .item(item_reg), .burst(burst)
    );

    dhc_drain u_drain (
        .clk(clk), .rst_n(rst_n), .load(take_item), .burst(burst),
        .empty(drain_empty), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_channel(out_ch.channel), .out_command(out_ch.command),
        .out_last(out_ch.last)
    );
endmodule
